[rtl/core/two_bone_vertex_skinning_assert.svh]
// Assertion macros shared by the skinning block's RTL files.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TWO_BONE_VERTEX_SKINNING_ASSERT_SVH
`define TWO_BONE_VERTEX_SKINNING_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define TBVS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that implies another one in the same cycle.
`define TBVS_ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// A condition that implies another one in the next cycle.
`define TBVS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/tbvs_pkg.sv]
// Package of the two-bone skinning block: sizes, codes, helper functions and
// the structs passed between its modules. Depends on nothing.
package tbvs_pkg;

    localparam int BONE_SLOTS = 64;
    localparam int BONE_AW    = $clog2(BONE_SLOTS > 1 ? BONE_SLOTS : 2);
    localparam int BONE_W     = 6;
    localparam int OOR_W      = 9;
    localparam int WORD_W     = 4;
    localparam int AXES       = 3;
    localparam int ROT_WORDS  = AXES * AXES;
    localparam int TRN_WORDS  = AXES;
    localparam int FRAC_BITS  = 12;

    localparam int COORD_W    = 16;
    localparam int ROT_W      = 16;
    localparam int TRN_W      = 32;
    localparam int WT_W       = 8;
    localparam int PROD_W     = ROT_W + COORD_W;
    localparam int ROWSUM_W   = PROD_W + 2;
    localparam int SHR_W      = ROWSUM_W - FRAC_BITS;
    localparam int POSE_W     = TRN_W + 1;
    localparam int BLEND_W    = POSE_W + WT_W + 1;
    localparam int MAG_BYTES  = (BLEND_W + 7) / 8;
    localparam int MAG_W      = MAG_BYTES * 8;
    localparam int BSUM_W     = 8 + $clog2(MAG_BYTES);
    localparam int FOLD_W     = 9;

    localparam logic [WT_W-1:0] WEIGHT_FULL = 8'd255;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_SKIN = 1'b1
    } t_action;

    typedef logic [BONE_W-1:0]  t_bone;
    typedef logic [BONE_AW-1:0] t_addr;
    typedef logic [WORD_W-1:0]  t_word;

    typedef struct packed {
        logic               valid;
        t_bone              bone;
        t_word              word;
        logic [TRN_W-1:0]   value;
    } t_wr_req;

    typedef struct packed {
        logic                           valid;
        t_bone                          bone0;
        t_bone                          bone1;
        logic [AXES-1:0][COORD_W-1:0]   vert;
        logic [WT_W-1:0]                weight;
        logic                           last;
    } t_skin_req;

    typedef struct packed {
        logic                               valid;
        logic [1:0][AXES-1:0][POSE_W-1:0]   p;
        logic [WT_W-1:0]                    weight;
        logic                               last;
    } t_pose;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               done;
    } t_vertex;

    function automatic logic bone_oor(input t_bone b);
        return OOR_W'(b) >= OOR_W'(BONE_SLOTS);
    endfunction

    function automatic t_addr to_addr(input t_bone b);
        return BONE_AW'(b);
    endfunction

endpackage

[rtl/core/tbvs_in_if.sv]
// Input channel of the skinning block: valid/ready handshake with one
// matrix-load or vertex-skin transaction. Depends on tbvs_pkg.
interface tbvs_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    tbvs_pkg::t_bone                        load_bone;
    tbvs_pkg::t_word                        word_index;
    logic signed [tbvs_pkg::TRN_W-1:0]      word_value;
    logic signed [tbvs_pkg::COORD_W-1:0]    vert_x;
    logic signed [tbvs_pkg::COORD_W-1:0]    vert_y;
    logic signed [tbvs_pkg::COORD_W-1:0]    vert_z;
    tbvs_pkg::t_bone                        first_bone;
    tbvs_pkg::t_bone                        second_bone;
    logic [tbvs_pkg::WT_W-1:0]              first_weight;
    logic                                   last_vertex;

    modport source (
        output valid, action, load_bone, word_index, word_value, vert_x, vert_y, vert_z,
        output first_bone, second_bone, first_weight, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, action, load_bone, word_index, word_value, vert_x, vert_y, vert_z,
        input  first_bone, second_bone, first_weight, last_vertex,
        output ready
    );
endinterface

[rtl/core/tbvs_out_if.sv]
// Output channel of the skinning block: valid/ready handshake with one
// skinned vertex per transaction. Depends on tbvs_pkg.
interface tbvs_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tbvs_pkg::COORD_W-1:0]    skinned_x;
    logic signed [tbvs_pkg::COORD_W-1:0]    skinned_y;
    logic signed [tbvs_pkg::COORD_W-1:0]    skinned_z;
    logic                                   mesh_done;

    modport source (
        output valid, skinned_x, skinned_y, skinned_z, mesh_done,
        input  ready
    );

    modport sink (
        input  valid, skinned_x, skinned_y, skinned_z, mesh_done,
        output ready
    );
endinterface

[rtl/core/tbvs_ram.sv]
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module tbvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                         o_rdata_a,
    output logic [WIDTH-1:0]                         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/core/tbvs_xform.sv]
// Bone matrix memories and the two per-bone transforms (rotate, shift, translate).
// Depends on tbvs_pkg, tbvs_ram and the assertion header.
`include "two_bone_vertex_skinning_assert.svh"

module tbvs_xform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbvs_pkg::t_wr_req   i_wr,
    input  tbvs_pkg::t_skin_req i_req,
    input  logic                i_dn_ready,
    output logic                o_ready,
    output tbvs_pkg::t_pose     o_pose
);

    logic                                   wr_ok;
    tbvs_pkg::t_addr                        wr_addr;
    tbvs_pkg::t_addr                        rd_addr [2];
    logic [tbvs_pkg::ROT_WORDS-1:0]         rot_we;
    logic [tbvs_pkg::TRN_WORDS-1:0]         trn_we;
    logic [tbvs_pkg::ROT_W-1:0]             rot_q [2][tbvs_pkg::ROT_WORDS];
    logic [tbvs_pkg::TRN_W-1:0]             trn_q [2][tbvs_pkg::TRN_WORDS];
    logic                                   en_a, en_b, en_c, en_d;

    logic                                           r_a_v;
    logic [tbvs_pkg::AXES-1:0][tbvs_pkg::COORD_W-1:0] r_a_vert;
    logic [tbvs_pkg::WT_W-1:0]                      r_a_w;
    logic                                           r_a_last;
    logic [1:0]                                     r_a_oor;

    logic                                   r_b_v;
    logic signed [tbvs_pkg::PROD_W-1:0]     r_b_prod [2][tbvs_pkg::ROT_WORDS];
    logic signed [tbvs_pkg::PROD_W-1:0]     n_b_prod [2][tbvs_pkg::ROT_WORDS];
    logic signed [tbvs_pkg::TRN_W-1:0]      r_b_trn [2][tbvs_pkg::TRN_WORDS];
    logic signed [tbvs_pkg::TRN_W-1:0]      n_b_trn [2][tbvs_pkg::TRN_WORDS];
    logic [tbvs_pkg::WT_W-1:0]              r_b_w;
    logic                                   r_b_last;

    logic signed [tbvs_pkg::ROWSUM_W-1:0]   rsum [2][tbvs_pkg::AXES];
    logic                                   r_c_v;
    logic signed [tbvs_pkg::SHR_W-1:0]      r_c_shr [2][tbvs_pkg::AXES];
    logic signed [tbvs_pkg::SHR_W-1:0]      n_c_shr [2][tbvs_pkg::AXES];
    logic signed [tbvs_pkg::TRN_W-1:0]      r_c_trn [2][tbvs_pkg::AXES];
    logic [tbvs_pkg::WT_W-1:0]              r_c_w;
    logic                                   r_c_last;

    logic                                   r_d_v;
    logic signed [tbvs_pkg::POSE_W-1:0]     r_d_p [2][tbvs_pkg::AXES];
    logic signed [tbvs_pkg::POSE_W-1:0]     n_d_p [2][tbvs_pkg::AXES];
    logic [tbvs_pkg::WT_W-1:0]              r_d_w;
    logic                                   r_d_last;

    always_comb begin
        wr_ok      = i_wr.valid && !tbvs_pkg::bone_oor(i_wr.bone);
        wr_addr    = tbvs_pkg::to_addr(i_wr.bone);
        rd_addr[0] = tbvs_pkg::to_addr(i_req.bone0);
        rd_addr[1] = tbvs_pkg::to_addr(i_req.bone1);
        for (int k = 0; k < tbvs_pkg::ROT_WORDS; k++) begin
            rot_we[k] = wr_ok && (i_wr.word == tbvs_pkg::WORD_W'(k));
        end
        for (int j = 0; j < tbvs_pkg::TRN_WORDS; j++) begin
            trn_we[j] = wr_ok && (i_wr.word == tbvs_pkg::WORD_W'(tbvs_pkg::ROT_WORDS + j));
        end
    end

    for (genvar k = 0; k < tbvs_pkg::ROT_WORDS; k++) begin : g_rot
        tbvs_ram #(
            .WIDTH (tbvs_pkg::ROT_W),
            .DEPTH (tbvs_pkg::BONE_SLOTS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (rot_we[k]),
            .i_waddr   (wr_addr),
            .i_wdata   (i_wr.value[tbvs_pkg::ROT_W-1:0]),
            .i_re      (en_a),
            .i_raddr_a (rd_addr[0]),
            .i_raddr_b (rd_addr[1]),
            .o_rdata_a (rot_q[0][k]),
            .o_rdata_b (rot_q[1][k])
        );
    end

    for (genvar j = 0; j < tbvs_pkg::TRN_WORDS; j++) begin : g_trn
        tbvs_ram #(
            .WIDTH (tbvs_pkg::TRN_W),
            .DEPTH (tbvs_pkg::BONE_SLOTS)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (trn_we[j]),
            .i_waddr   (wr_addr),
            .i_wdata   (i_wr.value),
            .i_re      (en_a),
            .i_raddr_a (rd_addr[0]),
            .i_raddr_b (rd_addr[1]),
            .o_rdata_a (trn_q[0][j]),
            .o_rdata_b (trn_q[1][j])
        );
    end

    assign en_d    = !r_d_v || i_dn_ready;
    assign en_c    = !r_c_v || en_d;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    // A bone index beyond the table reads as an all-zero matrix.
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            for (int r = 0; r < tbvs_pkg::AXES; r++) begin
                for (int c = 0; c < tbvs_pkg::AXES; c++) begin
                    if (r_a_oor[b]) begin
                        n_b_prod[b][r*tbvs_pkg::AXES+c] = '0;
                    end else begin
                        n_b_prod[b][r*tbvs_pkg::AXES+c] =
                            tbvs_pkg::PROD_W'($signed(rot_q[b][r*tbvs_pkg::AXES+c])) *
                            tbvs_pkg::PROD_W'($signed(r_a_vert[c]));
                    end
                end
                if (r_a_oor[b]) begin
                    n_b_trn[b][r] = '0;
                end else begin
                    n_b_trn[b][r] = $signed(trn_q[b][r]);
                end
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            for (int r = 0; r < tbvs_pkg::AXES; r++) begin
                rsum[b][r] = tbvs_pkg::ROWSUM_W'(r_b_prod[b][r*tbvs_pkg::AXES])
                           + tbvs_pkg::ROWSUM_W'(r_b_prod[b][r*tbvs_pkg::AXES+1])
                           + tbvs_pkg::ROWSUM_W'(r_b_prod[b][r*tbvs_pkg::AXES+2]);
                n_c_shr[b][r] = tbvs_pkg::SHR_W'(rsum[b][r] >>> tbvs_pkg::FRAC_BITS);
                n_d_p[b][r]   = tbvs_pkg::POSE_W'(r_c_shr[b][r])
                              + tbvs_pkg::POSE_W'(r_c_trn[b][r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_req.valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
            if (en_d) begin
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_vert   <= i_req.vert;
            r_a_w      <= i_req.weight;
            r_a_last   <= i_req.last;
            r_a_oor[0] <= tbvs_pkg::bone_oor(i_req.bone0);
            r_a_oor[1] <= tbvs_pkg::bone_oor(i_req.bone1);
        end
        if (en_b) begin
            r_b_prod <= n_b_prod;
            r_b_trn  <= n_b_trn;
            r_b_w    <= r_a_w;
            r_b_last <= r_a_last;
        end
        if (en_c) begin
            r_c_shr  <= n_c_shr;
            r_c_trn  <= r_b_trn;
            r_c_w    <= r_b_w;
            r_c_last <= r_b_last;
        end
        if (en_d) begin
            r_d_p    <= n_d_p;
            r_d_w    <= r_c_w;
            r_d_last <= r_c_last;
        end
    end

    always_comb begin
        o_pose.valid  = r_d_v;
        o_pose.weight = r_d_w;
        o_pose.last   = r_d_last;
        for (int b = 0; b < 2; b++) begin
            for (int r = 0; r < tbvs_pkg::AXES; r++) begin
                o_pose.p[b][r] = r_d_p[b][r];
            end
        end
    end

    `TBVS_ASSERT_HOLDS(a_wr_skin_excl, !(i_wr.valid && i_req.valid), "load and skin together")
    `TBVS_ASSERT_IMPLIES(a_stall_full, !o_ready,
        r_a_v && r_b_v && r_c_v && r_d_v && !i_dn_ready, "stall with a bubble in the pipe")
    `TBVS_ASSERT_NEXT(a_a_hold, r_a_v && !en_b, r_a_v, "stage A lost a vertex")

endmodule

[rtl/core/tbvs_blend.sv]
// Weight blend of the two bone results, division by 255 toward zero, and the
// output register. Depends on tbvs_pkg and the assertion header.
`include "two_bone_vertex_skinning_assert.svh"

module tbvs_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbvs_pkg::t_pose     i_pose,
    output logic                o_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output tbvs_pkg::t_vertex   o_out
);

    logic                                   en_e, en_f, en_g, en_h, en_i, en_out;
    logic                                   full;
    logic [tbvs_pkg::WT_W-1:0]              w1;

    logic                                   r_e_v;
    logic signed [tbvs_pkg::BLEND_W-1:0]    r_e_m [2][tbvs_pkg::AXES];
    logic signed [tbvs_pkg::BLEND_W-1:0]    n_e_m [2][tbvs_pkg::AXES];
    logic                                   r_e_last;

    logic                                   r_f_v;
    logic signed [tbvs_pkg::BLEND_W-1:0]    r_f_sum [tbvs_pkg::AXES];
    logic                                   r_f_last;

    logic                                   r_g_v;
    logic [tbvs_pkg::BLEND_W-1:0]           r_g_mag [tbvs_pkg::AXES];
    logic [tbvs_pkg::BLEND_W-1:0]           n_g_mag [tbvs_pkg::AXES];
    logic [tbvs_pkg::AXES-1:0]              r_g_neg;
    logic                                   r_g_last;

    logic [tbvs_pkg::MAG_W-1:0]             pad [tbvs_pkg::AXES];
    logic                                   r_h_v;
    logic [tbvs_pkg::BSUM_W-1:0]            r_h_bsum [tbvs_pkg::AXES];
    logic [tbvs_pkg::BSUM_W-1:0]            n_h_bsum [tbvs_pkg::AXES];
    logic [tbvs_pkg::COORD_W-1:0]           r_h_low [tbvs_pkg::AXES];
    logic [tbvs_pkg::AXES-1:0]              r_h_neg;
    logic                                   r_h_last;

    logic [tbvs_pkg::FOLD_W-1:0]            fold [tbvs_pkg::AXES];
    logic                                   r_i_v;
    logic [tbvs_pkg::WT_W-1:0]              r_i_rem [tbvs_pkg::AXES];
    logic [tbvs_pkg::WT_W-1:0]              n_i_rem [tbvs_pkg::AXES];
    logic [tbvs_pkg::COORD_W-1:0]           r_i_low [tbvs_pkg::AXES];
    logic [tbvs_pkg::AXES-1:0]              r_i_neg;
    logic                                   r_i_last;

    logic [tbvs_pkg::COORD_W-1:0]           diff [tbvs_pkg::AXES];
    logic [tbvs_pkg::COORD_W-1:0]           quo [tbvs_pkg::AXES];
    logic [tbvs_pkg::COORD_W-1:0]           n_res [tbvs_pkg::AXES];
    logic                                   r_out_valid;
    tbvs_pkg::t_vertex                      r_out;

    assign en_out  = !r_out_valid || i_out_ready;
    assign en_i    = !r_i_v || en_out;
    assign en_h    = !r_h_v || en_i;
    assign en_g    = !r_g_v || en_h;
    assign en_f    = !r_f_v || en_g;
    assign en_e    = !r_e_v || en_f;
    assign o_ready = en_e;

    // With full weight the second bone is not used and may never have been loaded.
    always_comb begin
        full = (i_pose.weight == tbvs_pkg::WEIGHT_FULL);
        w1   = tbvs_pkg::WEIGHT_FULL - i_pose.weight;
        for (int r = 0; r < tbvs_pkg::AXES; r++) begin
            n_e_m[0][r] = tbvs_pkg::BLEND_W'($signed(i_pose.p[0][r])) *
                          tbvs_pkg::BLEND_W'($signed({1'b0, i_pose.weight}));
            if (full) begin
                n_e_m[1][r] = '0;
            end else begin
                n_e_m[1][r] = tbvs_pkg::BLEND_W'($signed(i_pose.p[1][r])) *
                              tbvs_pkg::BLEND_W'($signed({1'b0, w1}));
            end
        end
    end

    // The remainder by 255 is the byte digit sum folded once, since 256 is 1
    // modulo 255. The low quotient bits then follow from the inverse of 255
    // modulo 2^16, which is -257.
    always_comb begin
        for (int r = 0; r < tbvs_pkg::AXES; r++) begin
            if (r_f_sum[r][tbvs_pkg::BLEND_W-1]) begin
                n_g_mag[r] = tbvs_pkg::BLEND_W'(-r_f_sum[r]);
            end else begin
                n_g_mag[r] = tbvs_pkg::BLEND_W'(r_f_sum[r]);
            end

            pad[r]      = tbvs_pkg::MAG_W'(r_g_mag[r]);
            n_h_bsum[r] = '0;
            for (int i = 0; i < tbvs_pkg::MAG_BYTES; i++) begin
                n_h_bsum[r] = n_h_bsum[r] + tbvs_pkg::BSUM_W'(pad[r][8*i +: 8]);
            end

            fold[r] = tbvs_pkg::FOLD_W'(r_h_bsum[r][7:0])
                    + tbvs_pkg::FOLD_W'(r_h_bsum[r][tbvs_pkg::BSUM_W-1:8]);
            if (fold[r] >= tbvs_pkg::FOLD_W'(tbvs_pkg::WEIGHT_FULL)) begin
                n_i_rem[r] = tbvs_pkg::WT_W'(fold[r] - tbvs_pkg::FOLD_W'(tbvs_pkg::WEIGHT_FULL));
            end else begin
                n_i_rem[r] = tbvs_pkg::WT_W'(fold[r]);
            end

            diff[r] = tbvs_pkg::COORD_W'(r_i_rem[r]) - r_i_low[r];
            quo[r]  = diff[r] + {diff[r][7:0], 8'b0};
            if (r_i_neg[r]) begin
                n_res[r] = -quo[r];
            end else begin
                n_res[r] = quo[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v       <= 1'b0;
            r_f_v       <= 1'b0;
            r_g_v       <= 1'b0;
            r_h_v       <= 1'b0;
            r_i_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_e) begin
                r_e_v <= i_pose.valid;
            end
            if (en_f) begin
                r_f_v <= r_e_v;
            end
            if (en_g) begin
                r_g_v <= r_f_v;
            end
            if (en_h) begin
                r_h_v <= r_g_v;
            end
            if (en_i) begin
                r_i_v <= r_h_v;
            end
            if (en_out) begin
                r_out_valid <= r_i_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_m    <= n_e_m;
            r_e_last <= i_pose.last;
        end
        if (en_f) begin
            for (int r = 0; r < tbvs_pkg::AXES; r++) begin
                r_f_sum[r] <= r_e_m[0][r] + r_e_m[1][r];
            end
            r_f_last <= r_e_last;
        end
        if (en_g) begin
            for (int r = 0; r < tbvs_pkg::AXES; r++) begin
                r_g_neg[r] <= r_f_sum[r][tbvs_pkg::BLEND_W-1];
            end
            r_g_mag  <= n_g_mag;
            r_g_last <= r_f_last;
        end
        if (en_h) begin
            for (int r = 0; r < tbvs_pkg::AXES; r++) begin
                r_h_low[r] <= r_g_mag[r][tbvs_pkg::COORD_W-1:0];
            end
            r_h_bsum <= n_h_bsum;
            r_h_neg  <= r_g_neg;
            r_h_last <= r_g_last;
        end
        if (en_i) begin
            r_i_rem  <= n_i_rem;
            r_i_low  <= r_h_low;
            r_i_neg  <= r_h_neg;
            r_i_last <= r_h_last;
        end
        if (en_out) begin
            r_out.x    <= n_res[0];
            r_out.y    <= n_res[1];
            r_out.z    <= n_res[2];
            r_out.done <= r_i_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TBVS_ASSERT_IMPLIES(a_rem_range, r_i_v,
        r_i_rem[0] < tbvs_pkg::WEIGHT_FULL && r_i_rem[1] < tbvs_pkg::WEIGHT_FULL &&
        r_i_rem[2] < tbvs_pkg::WEIGHT_FULL, "remainder by 255 out of range")
    `TBVS_ASSERT_IMPLIES(a_stall_full, !o_ready,
        r_e_v && r_f_v && r_g_v && r_h_v && r_i_v && r_out_valid && !i_out_ready,
        "stall with a bubble in the pipe")
    `TBVS_ASSERT_NEXT(a_i_hold, r_i_v && !en_out, r_i_v, "last stage lost a vertex")

endmodule

[rtl/core/two_bone_vertex_skinning.sv]
// Top level of the two-bone linear blend skinning block.
// Depends on tbvs_pkg, tbvs_in_if, tbvs_out_if, tbvs_xform and tbvs_blend.
//
// Usage:
// The input channel i_item carries two kinds of transaction. A load transaction
// (action 0) writes one word of a bone matrix: rotation words 0 to 8 in row order,
// translation words 9 to 11. It gives no result. A skin transaction (action 1)
// carries a vertex, two bone indices and the first bone's weight out of 255, and
// gives one skinned vertex on the output channel o_result, in order.
// The matrix words live in twelve memories, one per word, each read for both bones
// at once, so one transaction is taken in every cycle unless the pipeline stalls.
// A load takes effect at once: a skin transaction in the next cycle sees it.
// Reset empties the pipeline; the matrix memories are not cleared, so each bone
// must be loaded before it is used.
// When the receiver holds ready low, the result waits in the output register and
// the pipeline keeps taking input until all ten stages are full.
module two_bone_vertex_skinning (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbvs_in_if.sink     i_item,
    tbvs_out_if.source  o_result
);

    tbvs_pkg::t_wr_req      wr;
    tbvs_pkg::t_skin_req    req;
    tbvs_pkg::t_pose        pose;
    tbvs_pkg::t_vertex      vtx;
    logic                   xf_ready;
    logic                   bl_ready;
    logic                   out_valid;
    tbvs_pkg::t_action      act;

    always_comb begin
        act       = tbvs_pkg::t_action'(i_item.action);
        wr.valid  = i_item.valid && xf_ready && (act == tbvs_pkg::ACT_LOAD);
        wr.bone   = i_item.load_bone;
        wr.word   = i_item.word_index;
        wr.value  = i_item.word_value;

        req.valid   = i_item.valid && (act == tbvs_pkg::ACT_SKIN);
        req.bone0   = i_item.first_bone;
        req.bone1   = i_item.second_bone;
        req.vert[0] = i_item.vert_x;
        req.vert[1] = i_item.vert_y;
        req.vert[2] = i_item.vert_z;
        req.weight  = i_item.first_weight;
        req.last    = i_item.last_vertex;
    end

    tbvs_xform u_xform (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_req      (req),
        .i_dn_ready (bl_ready),
        .o_ready    (xf_ready),
        .o_pose     (pose)
    );

    tbvs_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pose      (pose),
        .o_ready     (bl_ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .o_out       (vtx)
    );

    assign i_item.ready       = xf_ready;
    assign o_result.valid     = out_valid;
    assign o_result.skinned_x = vtx.x;
    assign o_result.skinned_y = vtx.y;
    assign o_result.skinned_z = vtx.z;
    assign o_result.mesh_done = vtx.done;

endmodule

[tb/sv/tb.sv]
// Testbench of the two-bone skinning block: loads bone matrices, streams vertex
// transactions and checks every skinned vertex against its own prediction.
// Depends on tbvs_pkg, tbvs_in_if, tbvs_out_if and two_bone_vertex_skinning.
module tb;
    import tbvs_pkg::*;

    localparam int     WORD_TRN_X    = ROT_WORDS;
    localparam int     WORD_TOTAL    = ROT_WORDS + TRN_WORDS;
    localparam longint WEIGHT_SPAN   = 255;
    localparam int     RANDOM_ITEMS  = 1630;
    localparam int     PRESSURE_AT   = 500;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     PRINT_LIMIT   = 50;

    typedef struct packed {
        t_action                    action;
        t_bone                      load_bone;
        t_word                      word_index;
        logic signed [TRN_W-1:0]    word_value;
        logic signed [COORD_W-1:0]  vert_x;
        logic signed [COORD_W-1:0]  vert_y;
        logic signed [COORD_W-1:0]  vert_z;
        t_bone                      first_bone;
        t_bone                      second_bone;
        logic [WT_W-1:0]            first_weight;
        logic                       last_vertex;
    } t_skin_txn;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    class skinned_vertex_checker;
        logic signed [ROT_W-1:0] rot_mem [BONE_SLOTS*ROT_WORDS];
        logic signed [TRN_W-1:0] trn_mem [BONE_SLOTS*TRN_WORDS];
        t_vertex                 expected_vertices [$];
        int                      errors;
        int                      vertex_count;

        function new();
            errors       = 0;
            vertex_count = 0;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        function void bone_pose(int bone, longint vec [3], output longint pose [3]);
            longint row_sum;
            longint rot_word;
            longint trn_word;
            for (int r = 0; r < AXES; r++) begin
                row_sum = 0;
                for (int c = 0; c < AXES; c++) begin
                    rot_word = rot_mem[bone*ROT_WORDS + r*AXES + c];
                    row_sum  = row_sum + rot_word * vec[c];
                end
                trn_word = trn_mem[bone*TRN_WORDS + r];
                pose[r]  = (row_sum >>> FRAC_BITS) + trn_word;
            end
        endfunction

        function void note_accepted(t_skin_txn t);
            longint  vec [3];
            longint  pose0 [3];
            longint  pose1 [3];
            longint  blended [3];
            longint  w0;
            t_vertex vtx;
            int      word;
            word = int'(t.word_index);
            if (t.action == ACT_LOAD) begin
                if (word < WORD_TRN_X)
                    rot_mem[int'(t.load_bone)*ROT_WORDS + word] = t.word_value[ROT_W-1:0];
                else if (word < WORD_TOTAL)
                    trn_mem[int'(t.load_bone)*TRN_WORDS + word - WORD_TRN_X] = t.word_value;
                return;
            end
            vec[0] = t.vert_x;
            vec[1] = t.vert_y;
            vec[2] = t.vert_z;
            w0     = t.first_weight;
            bone_pose(int'(t.first_bone), vec, pose0);
            bone_pose(int'(t.second_bone), vec, pose1);
            for (int r = 0; r < AXES; r++) begin
                if (t.first_weight == WEIGHT_FULL)
                    blended[r] = pose0[r];
                else
                    blended[r] = (pose0[r] * w0 + pose1[r] * (WEIGHT_SPAN - w0)) / WEIGHT_SPAN;
            end
            vtx.x    = blended[0][COORD_W-1:0];
            vtx.y    = blended[1][COORD_W-1:0];
            vtx.z    = blended[2][COORD_W-1:0];
            vtx.done = t.last_vertex;
            expected_vertices.push_back(vtx);
        endfunction

        task check_vertex(t_vertex got);
            t_vertex want;
            if (expected_vertices.size() == 0) begin
                report($sformatf("skinned vertex %0d arrived with none expected",
                                 vertex_count));
            end else begin
                want = expected_vertices.pop_front();
                if (got !== want)
                    report($sformatf({"vertex %0d: got (%0d,%0d,%0d) done %b, ",
                                      "expected (%0d,%0d,%0d) done %b"}, vertex_count,
                                     $signed(got.x), $signed(got.y), $signed(got.z),
                                     got.done, $signed(want.x), $signed(want.y),
                                     $signed(want.z), want.done));
            end
            vertex_count++;
        endtask

        function int vertices_outstanding();
            return expected_vertices.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tbvs_in_if  item_if ();
    tbvs_out_if result_if ();

    two_bone_vertex_skinning dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    skinned_vertex_checker vtx_check;
    logic [WORD_TOTAL-1:0] words_loaded [BONE_SLOTS];
    int  burst_left;
    int  cycle_count;
    bit  hold_req;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && item_if.valid && item_if.ready) begin
            vtx_check.note_accepted('{t_action'(item_if.action), item_if.load_bone,
                                      item_if.word_index, item_if.word_value,
                                      item_if.vert_x, item_if.vert_y, item_if.vert_z,
                                      item_if.first_bone, item_if.second_bone,
                                      item_if.first_weight, item_if.last_vertex});
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            vtx_check.check_vertex('{result_if.skinned_x, result_if.skinned_y,
                                     result_if.skinned_z, result_if.mesh_done});
        end
    end

    initial begin
        t_rx_mode mode;
        int       span;
        int       hold_count;
        result_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 80);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (hold_req && !hold_done) begin
                    result_if.ready = 1'b0;
                    for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++)
                        @(negedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        RX_OPEN:   result_if.ready = 1'b1;
                        RX_RANDOM: result_if.ready = 1'($urandom_range(0, 1));
                        RX_SPARSE: result_if.ready = ($urandom_range(0, 3) == 0);
                        default:   result_if.ready = k[1];
                    endcase
                end
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 16'sh8000;
                1:       v = 16'sh7FFF;
                2:       v = 16'sh0000;
                default: v = 16'shFFFF;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [TRN_W-1:0] pick_word_value();
        logic signed [TRN_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 3) == 0)
            v[TRN_W-1:FRAC_BITS+1] = {(TRN_W-FRAC_BITS-1){v[FRAC_BITS]}};
        return v;
    endfunction

    function automatic t_skin_txn random_txn();
        t_skin_txn t;
        t.action       = t_action'($urandom_range(0, 1));
        t.load_bone    = t_bone'($urandom);
        t.word_index   = t_word'($urandom);
        t.word_value   = $urandom;
        t.vert_x       = pick_coord();
        t.vert_y       = pick_coord();
        t.vert_z       = pick_coord();
        t.first_bone   = t_bone'($urandom);
        t.second_bone  = t_bone'($urandom);
        t.first_weight = WT_W'($urandom);
        t.last_vertex  = 1'($urandom);
        return t;
    endfunction

    function automatic t_skin_txn make_load(int bone, int word, logic [TRN_W-1:0] value);
        t_skin_txn t;
        t            = random_txn();
        t.action     = ACT_LOAD;
        t.load_bone  = t_bone'(bone);
        t.word_index = t_word'(word);
        t.word_value = value;
        return t;
    endfunction

    function automatic t_skin_txn make_skin(logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy,
                                            logic [COORD_W-1:0] vz, int b0, int b1,
                                            int weight, bit last);
        t_skin_txn t;
        t              = random_txn();
        t.action       = ACT_SKIN;
        t.vert_x       = vx;
        t.vert_y       = vy;
        t.vert_z       = vz;
        t.first_bone   = t_bone'(b0);
        t.second_bone  = t_bone'(b1);
        t.first_weight = WT_W'(weight);
        t.last_vertex  = last;
        return t;
    endfunction

    task idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            item_if.valid = 1'b0;
        end
    endtask

    task send_item(t_skin_txn t);
        if (burst_left == 0) begin
            if ($urandom_range(0, 99) < 15)
                idle_cycles($urandom_range(8, 20));
            else
                idle_cycles($urandom_range(0, 4));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (t.action == ACT_LOAD && int'(t.word_index) < WORD_TOTAL)
            words_loaded[t.load_bone][t.word_index] = 1'b1;
        @(negedge i_clk);
        item_if.action       = t.action;
        item_if.load_bone    = t.load_bone;
        item_if.word_index   = t.word_index;
        item_if.word_value   = t.word_value;
        item_if.vert_x       = t.vert_x;
        item_if.vert_y       = t.vert_y;
        item_if.vert_z       = t.vert_z;
        item_if.first_bone   = t.first_bone;
        item_if.second_bone  = t.second_bone;
        item_if.first_weight = t.first_weight;
        item_if.last_vertex  = t.last_vertex;
        item_if.valid        = 1'b1;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
    endtask

    function automatic int pick_loaded_bone();
        int b;
        do b = $urandom_range(0, BONE_SLOTS - 1); while (!(&words_loaded[b]));
        return b;
    endfunction

    task send_random_skin();
        int b0;
        int b1;
        int weight;
        b0 = pick_loaded_bone();
        b1 = ($urandom_range(0, 9) == 0) ? b0 : pick_loaded_bone();
        case ($urandom_range(0, 9))
            0, 1:    weight = 255;
            2:       weight = 0;
            default: weight = $urandom_range(0, 255);
        endcase
        send_item(make_skin(pick_coord(), pick_coord(), pick_coord(), b0, b1, weight,
                            ($urandom_range(0, 7) == 0)));
    endtask

    initial begin
        logic [TRN_W-1:0] bone0_words [WORD_TOTAL];
        int sent;
        int next_slot;
        int offset;
        vtx_check  = new();
        burst_left = 0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        for (int b = 0; b < BONE_SLOTS; b++)
            words_loaded[b] = '0;
        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.action       = ACT_LOAD;
        item_if.load_bone    = '0;
        item_if.word_index   = '0;
        item_if.word_value   = '0;
        item_if.vert_x       = '0;
        item_if.vert_y       = '0;
        item_if.vert_z       = '0;
        item_if.first_bone   = '0;
        item_if.second_bone  = '0;
        item_if.first_weight = '0;
        item_if.last_vertex  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Rotation words carry junk in their upper halves, which must be dropped.
        bone0_words = '{32'h1234_8000, 32'h0000_7FFF, 32'hFFFF_0000, 32'h0000_1000,
                        32'hABCD_FFFF, 32'h7FFF_7FFF, 32'h8000_8000, 32'h5555_0800,
                        32'hFFFF_F000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000};
        for (int w = 0; w < WORD_TOTAL; w++)
            send_item(make_load(0, w, bone0_words[w]));
        send_item(make_load(0, WORD_TOTAL, 32'hDEAD_BEEF));
        send_item(make_load(0, 15, 32'h0BAD_F00D));
        send_item(make_skin(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 255, 1'b0));
        send_item(make_skin(16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 255, 1'b0));
        send_item(make_skin(16'sh8000, 16'sh7FFF, 16'sh0000, 0, 0, 0, 1'b0));
        send_item(make_skin(16'sh7FFF, 16'sh8000, 16'shFFFF, 0, 0, 1, 1'b0));
        send_item(make_skin(16'sh8000, 16'sh8000, 16'sh7FFF, 0, 0, 254, 1'b0));
        send_item(make_skin(16'sh0000, 16'sh0000, 16'sh0000, 0, 0, 128, 1'b1));
        send_item(make_skin(16'sh0001, 16'shFFFF, 16'sh8000, 0, 0, 127, 1'b1));

        sent      = 0;
        next_slot = 1;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= PRESSURE_AT)
                hold_req = 1'b1;
            if (next_slot < BONE_SLOTS && (next_slot < 3 || $urandom_range(0, 99) < 20)) begin
                offset = $urandom_range(0, WORD_TOTAL - 1);
                for (int k = 0; k < WORD_TOTAL; k++)
                    send_item(make_load(next_slot, (k + offset) % WORD_TOTAL,
                                        pick_word_value()));
                next_slot++;
                sent += WORD_TOTAL;
            end else if ($urandom_range(0, 99) < 12) begin
                send_item(make_load($urandom_range(0, BONE_SLOTS - 1), $urandom_range(0, 15),
                                    pick_word_value()));
                sent++;
            end else begin
                send_random_skin();
                sent++;
            end
        end
        idle_cycles(1);

        while (vtx_check.vertices_outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (vtx_check.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
